// ===== src/dpf_pkg.sv =====
// Package for the deduplicating packet FIFO: sizes, codes and item types.
`default_nettype none
package dpf_pkg;

    // Store depth and derived widths
    localparam int DEPTH   = 64;
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int GRP     = 8;
    localparam int GRP_W   = $clog2(GRP + 1);
    localparam int NGRP    = (DEPTH + GRP - 1) / GRP;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int ID_W    = 18;
    localparam int TIME_W  = 32;
    localparam int LIMIT_W = 7;
    localparam int MCNT_W  = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
    localparam logic [MCNT_W-1:0]  MCNT_MAX    = 7'd127;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FWD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CNT = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   source;
        logic [ID_W-1:0]   destination;
        logic [TIME_W-1:0] timestamp;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
    } in_item_t;

    typedef struct packed {
        logic              accepted;
        logic              popped_valid;
        logic [ID_W-1:0]   out_source;
        logic [ID_W-1:0]   out_destination;
        logic [TIME_W-1:0] out_timestamp;
        logic [MCNT_W-1:0] match_count;
    } out_item_t;

    typedef struct packed {
        logic [ID_W-1:0]   source;
        logic [ID_W-1:0]   destination;
        logic [TIME_W-1:0] timestamp;
    } entry_t;

    // Controls broadcast to every cell
    typedef struct packed {
        logic cmp_en;
        logic shift;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== src/dpf_cell.sv =====
// One storage cell of the queue: entry register, shift from neighbor, match compares.
`default_nettype none
module dpf_cell (
    input  wire                  aclk,
    input  dpf_pkg::cell_ctrl_t  ctrl,
    input  wire                  wr_en,
    input  wire                  active,
    input  dpf_pkg::in_item_t    req,
    input  dpf_pkg::entry_t      next_entry,
    output dpf_pkg::entry_t      entry,
    output logic                 dup_hit,
    output logic                 cnt_hit
);

    dpf_pkg::entry_t entry_reg;
    dpf_pkg::entry_t entry_next;
    logic            dup_hit_reg;
    logic            dup_hit_next;
    logic            cnt_hit_reg;
    logic            cnt_hit_next;

    // Entry update: new write wins over a shift from the neighbor
    always_comb begin
        entry_next = entry_reg;
        if (wr_en) begin
            entry_next.source      = req.source;
            entry_next.destination = req.destination;
            entry_next.timestamp   = req.timestamp;
        end else if (ctrl.shift) begin
            entry_next = next_entry;
        end
    end

    // Exact-triple and destination/time-window matches, gated by occupancy
    always_comb begin
        dup_hit_next = dup_hit_reg;
        cnt_hit_next = cnt_hit_reg;
        if (ctrl.cmp_en) begin
            dup_hit_next = active &&
                           (entry_reg.source == req.source) &&
                           (entry_reg.destination == req.destination) &&
                           (entry_reg.timestamp == req.timestamp);
            cnt_hit_next = active &&
                           (entry_reg.destination == req.destination) &&
                           (entry_reg.timestamp >= req.start_time) &&
                           (entry_reg.timestamp <= req.end_time);
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg   <= entry_next;
        dup_hit_reg <= dup_hit_next;
        cnt_hit_reg <= cnt_hit_next;
    end

    assign entry   = entry_reg;
    assign dup_hit = dup_hit_reg;
    assign cnt_hit = cnt_hit_reg;

endmodule
`default_nettype wire

// ===== src/dpf_popcount.sv =====
// Two-stage registered popcount over the per-cell hit bits.
`default_nettype none
module dpf_popcount (
    input  wire                          aclk,
    input  wire [dpf_pkg::DEPTH-1:0]     bits,
    output logic [dpf_pkg::CNT_W-1:0]    total
);

    logic [dpf_pkg::NGRP*dpf_pkg::GRP-1:0] bits_pad;
    logic [dpf_pkg::GRP_W-1:0]             part_reg  [dpf_pkg::NGRP];
    logic [dpf_pkg::GRP_W-1:0]             part_next [dpf_pkg::NGRP];
    logic [dpf_pkg::CNT_W-1:0]             total_reg;
    logic [dpf_pkg::CNT_W-1:0]             total_next;

    assign bits_pad = (dpf_pkg::NGRP * dpf_pkg::GRP)'(bits);

    // Stage 1: count each group of eight
    always_comb begin
        for (int g = 0; g < dpf_pkg::NGRP; g++) begin
            part_next[g] = '0;
            for (int b = 0; b < dpf_pkg::GRP; b++) begin
                part_next[g] = part_next[g] +
                               dpf_pkg::GRP_W'(bits_pad[g*dpf_pkg::GRP + b]);
            end
        end
    end

    // Stage 2: add the group counts
    always_comb begin
        total_next = '0;
        for (int g = 0; g < dpf_pkg::NGRP; g++) begin
            total_next = total_next + dpf_pkg::CNT_W'(part_reg[g]);
        end
    end

    always_ff @(posedge aclk) begin
        part_reg  <= part_next;
        total_reg <= total_next;
    end

    assign total = total_reg;

endmodule
`default_nettype wire

// ===== src/dedup_packet_fifo_with_range_count_top.sv =====
// An item is taken only in S_IDLE and then runs through S_CMP, S_UPD, S_SUM
// and S_FIN, where its result is registered; no new item is taken before that.
// The cell compare register and the two-stage popcount tree set these steps.
// A waiting result does not block the next item until its result is to be stored.
// Reset (aresetn low, synchronous): queue empty, capacity limit 64,
// no result pending. Cell contents are not cleared.
`default_nettype none
module dedup_packet_fifo_with_range_count_top (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  dpf_pkg::in_item_t                s_data,
    output logic                             m_valid,
    input  wire                              m_ready,
    output dpf_pkg::out_item_t               m_data,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [dpf_pkg::LIMIT_W-1:0]       cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic [dpf_pkg::OCC_W-1:0]     occ_reg, occ_next;
    logic [dpf_pkg::LIMIT_W-1:0]   limit_reg, limit_next;
    logic                          m_valid_reg, m_valid_next;
    dpf_pkg::out_item_t            m_data_reg, m_data_next;
    dpf_pkg::in_item_t             req_reg, req_next;
    logic                          acc_reg, acc_next;
    logic                          popv_reg, popv_next;
    dpf_pkg::entry_t               pop_reg, pop_next;

    logic [dpf_pkg::OCC_W-1:0]     eff_limit;
    logic [dpf_pkg::OCC_W-1:0]     wr_pos;
    logic                          wr_any;
    dpf_pkg::cell_ctrl_t           ctrl;
    logic [dpf_pkg::DEPTH-1:0]     active_vec;
    logic [dpf_pkg::DEPTH-1:0]     wr_vec;
    logic [dpf_pkg::DEPTH-1:0]     dup_vec;
    logic [dpf_pkg::DEPTH-1:0]     cnt_vec;
    dpf_pkg::entry_t               cell_entry [dpf_pkg::DEPTH];
    logic [dpf_pkg::CNT_W-1:0]     cnt_total;
    logic [dpf_pkg::MCNT_W-1:0]    cnt_sat;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Limit clamped to 1..DEPTH
    always_comb begin
        if (limit_reg == '0) begin
            eff_limit = dpf_pkg::OCC_W'(1);
        end else if (32'(limit_reg) > 32'(dpf_pkg::DEPTH)) begin
            eff_limit = dpf_pkg::OCC_W'(dpf_pkg::DEPTH);
        end else begin
            eff_limit = dpf_pkg::OCC_W'(limit_reg);
        end
    end

    // Per-cell occupancy mask and write select
    always_comb begin
        for (int i = 0; i < dpf_pkg::DEPTH; i++) begin
            active_vec[i] = (32'(i) < 32'(occ_reg));
            wr_vec[i]     = wr_any && (32'(wr_pos) == 32'(i));
        end
    end

    // Cell chain; cell 0 holds the oldest entry
    genvar gi;
    generate
        for (gi = 0; gi < dpf_pkg::DEPTH; gi++) begin : g_cell
            dpf_pkg::entry_t nb;
            if (gi == dpf_pkg::DEPTH - 1) begin : g_last
                assign nb = cell_entry[gi];
            end else begin : g_mid
                assign nb = cell_entry[gi+1];
            end
            dpf_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .wr_en      (wr_vec[gi]),
                .active     (active_vec[gi]),
                .req        (req_reg),
                .next_entry (nb),
                .entry      (cell_entry[gi]),
                .dup_hit    (dup_vec[gi]),
                .cnt_hit    (cnt_vec[gi])
            );
        end
    endgenerate

    dpf_popcount u_popcount (
        .aclk  (aclk),
        .bits  (cnt_vec),
        .total (cnt_total)
    );

    // Saturate the count to the result field
    always_comb begin
        if (32'(cnt_total) > 32'(dpf_pkg::MCNT_MAX)) begin
            cnt_sat = dpf_pkg::MCNT_MAX;
        end else begin
            cnt_sat = dpf_pkg::MCNT_W'(cnt_total);
        end
    end

    // Sequencer and queue update
    always_comb begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        limit_next   = limit_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        req_next     = req_reg;
        acc_next     = acc_reg;
        popv_next    = popv_reg;
        pop_next     = pop_reg;
        wr_pos       = occ_reg;
        wr_any       = 1'b0;
        ctrl.cmp_en  = 1'b0;
        ctrl.shift   = 1'b0;

        if (cfg_valid && cfg_ready) begin
            limit_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    state_next = S_CMP;
                end
            end
            S_CMP: begin
                ctrl.cmp_en = 1'b1;
                state_next  = S_UPD;
            end
            S_UPD: begin
                acc_next  = 1'b0;
                popv_next = 1'b0;
                pop_next  = '0;
                case (req_reg.mode)
                    dpf_pkg::MODE_ADD: begin
                        if (!(|dup_vec)) begin
                            acc_next = 1'b1;
                            wr_any   = 1'b1;
                            if (32'(occ_reg) + 32'd1 > 32'(eff_limit)) begin
                                ctrl.shift = 1'b1;
                                wr_pos     = occ_reg - dpf_pkg::OCC_W'(1);
                            end else begin
                                occ_next = occ_reg + dpf_pkg::OCC_W'(1);
                            end
                        end
                    end
                    dpf_pkg::MODE_FWD: begin
                        if (occ_reg != '0) begin
                            popv_next  = 1'b1;
                            pop_next   = cell_entry[0];
                            ctrl.shift = 1'b1;
                            occ_next   = occ_reg - dpf_pkg::OCC_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
                state_next = S_SUM;
            end
            S_SUM: begin
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.accepted        = acc_reg;
                    m_data_next.popped_valid    = popv_reg;
                    m_data_next.out_source      = pop_reg.source;
                    m_data_next.out_destination = pop_reg.destination;
                    m_data_next.out_timestamp   = pop_reg.timestamp;
                    m_data_next.match_count     =
                        (req_reg.mode == dpf_pkg::MODE_CNT) ? cnt_sat : '0;
                    state_next                  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            limit_reg   <= dpf_pkg::LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        req_reg    <= req_next;
        acc_reg    <= acc_next;
        popv_reg   <= popv_next;
        pop_reg    <= pop_next;
    end

endmodule
`default_nettype wire

// ===== src/dpf_checker.sv =====
// Port-level checker for the deduplicating packet FIFO, bound to the top level.
`default_nettype none
module dpf_checker (
    input wire                  aclk,
    input wire                  aresetn,
    input wire                  s_valid,
    input wire                  s_ready,
    input wire                  m_valid,
    input wire                  m_ready,
    input dpf_pkg::out_item_t   m_data
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // One item in work at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after accepting an item");

    // Add and forward flags never together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.accepted && m_data.popped_valid))
        else $error("accepted and popped_valid both set");

    // A count result carries no add or forward flags
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.match_count != '0) |->
            !m_data.accepted && !m_data.popped_valid)
        else $error("count result with add or forward flag");

    // No popped packet means zero packet fields
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.popped_valid |->
            (m_data.out_source == '0) && (m_data.out_destination == '0) &&
            (m_data.out_timestamp == '0))
        else $error("packet fields nonzero without a pop");

endmodule

bind dedup_packet_fifo_with_range_count_top dpf_checker u_dpf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
